[hdl/crcfd_pkg.sv]
// Package for the CRC-16 framed packet deframer.
// Holds the beat types, protocol constants and the CRC-16/MODBUS byte update.
// No dependencies.
package crcfd_pkg;

  // Input beat: one received byte and the burst-start flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_start;
  } in_beat_t;

  // Output beat: one payload byte of an accepted frame, or the empty marker.
  typedef struct packed {
    logic [15:0] pkt_id;
    logic [7:0]  pkt_type;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_position;
    logic        has_payload;
    logic        last;
  } out_beat_t;

  // Release request from the parser to the release sequencer.
  typedef struct packed {
    logic        start;
    logic [15:0] pkt_id;
    logic [7:0]  pkt_type;
    logic [6:0]  length;
  } rel_req_t;

  // Framing bytes.
  localparam logic [7:0] Hdr0  = 8'hAA;
  localparam logic [7:0] Hdr1  = 8'h55;
  localparam logic [7:0] Tail0 = 8'h0D;
  localparam logic [7:0] Tail1 = 8'h0A;

  // CRC-16/MODBUS: reflected polynomial, all-ones seed, no final xor.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // One byte through the CRC, bit-serial over eight narrow steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/crcfd_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the payload buffer of the deframer. No dependencies.
module crcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/crcfd_parser.sv]
// Frame parser: header hunt, field capture, CRC check and payload writes.
// Depends on crcfd_pkg; writes payload bytes into the crcfd_ram buffer.
module crcfd_parser import crcfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  in_beat_t            beat_i,
  output logic                wr_en_o,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr_o,
  output logic [7:0]          wr_data_o,
  output rel_req_t            req_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Parser phases
  localparam logic [3:0] PhHunt1 = 4'd0;
  localparam logic [3:0] PhHunt2 = 4'd1;
  localparam logic [3:0] PhId0   = 4'd2;
  localparam logic [3:0] PhId1   = 4'd3;
  localparam logic [3:0] PhType  = 4'd4;
  localparam logic [3:0] PhLen0  = 4'd5;
  localparam logic [3:0] PhLen1  = 4'd6;
  localparam logic [3:0] PhData  = 4'd7;
  localparam logic [3:0] PhCrc0  = 4'd8;
  localparam logic [3:0] PhCrc1  = 4'd9;
  localparam logic [3:0] PhTail0 = 4'd10;
  localparam logic [3:0] PhTail1 = 4'd11;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic        disc_q, disc_d;

  logic [7:0]  b;
  logic [3:0]  ph;
  logic        disc_eff;
  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [6:0]  cnt_inc;

  assign b        = beat_i.rx_byte;
  assign crc_next = crc16_byte(crc_q, b);
  assign len_full = {b, len_lo_q};
  assign cnt_inc  = cnt_q + 7'd1;

  // Next-state logic for one accepted byte
  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    type_d   = type_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    disc_d   = disc_q;
    wr_en_o  = 1'b0;
    req_o    = '{start: 1'b0, pkt_id: id_q, pkt_type: type_q, length: len_q};

    // chunk start abandons any partial frame
    disc_eff = beat_i.chunk_start ? 1'b0 : disc_q;
    ph       = beat_i.chunk_start ? PhHunt1 : phase_q;

    if (accept_i) begin
      disc_d  = disc_eff;
      phase_d = ph;
      if (!disc_eff) begin
        case (ph)
          PhHunt2: begin
            if (b == Hdr1) begin
              crc_d   = CrcInit;
              phase_d = PhId0;
            end else begin
              phase_d = (b == Hdr0) ? PhHunt2 : PhHunt1;
            end
          end
          PhId0: begin
            crc_d   = crc_next;
            id_d    = {8'h00, b};
            phase_d = PhId1;
          end
          PhId1: begin
            crc_d   = crc_next;
            id_d    = {b, id_q[7:0]};
            phase_d = PhType;
          end
          PhType: begin
            crc_d   = crc_next;
            type_d  = b;
            phase_d = PhLen0;
          end
          PhLen0: begin
            crc_d    = crc_next;
            len_lo_d = b;
            phase_d  = PhLen1;
          end
          PhLen1: begin
            crc_d = crc_next;
            len_d = len_full[6:0];
            cnt_d = 7'd0;
            if (len_full > 16'(MAX_PAYLOAD)) begin
              disc_d  = 1'b1;
              phase_d = PhHunt1;
            end else if (len_full == 16'd0) begin
              phase_d = PhCrc0;
            end else begin
              phase_d = PhData;
            end
          end
          PhData: begin
            crc_d   = crc_next;
            wr_en_o = 1'b1;
            cnt_d   = cnt_inc;
            if (cnt_inc >= len_q) begin
              phase_d = PhCrc0;
            end
          end
          PhCrc0: begin
            rcrc_d  = {8'h00, b};
            phase_d = PhCrc1;
          end
          PhCrc1: begin
            rcrc_d  = {b, rcrc_q[7:0]};
            phase_d = PhTail0;
          end
          PhTail0: begin
            if (b == Tail0) begin
              phase_d = PhTail1;
            end else begin
              phase_d = (b == Hdr0) ? PhHunt2 : PhHunt1;
            end
          end
          PhTail1: begin
            if (b == Tail1) begin
              req_o.start = (rcrc_q == crc_q);
              phase_d     = PhHunt1;
            end else begin
              phase_d = (b == Hdr0) ? PhHunt2 : PhHunt1;
            end
          end
          default: begin
            phase_d = (b == Hdr0) ? PhHunt2 : PhHunt1;
          end
        endcase
      end
    end
  end

  assign wr_addr_o = cnt_q[AddrW-1:0];
  assign wr_data_o = b;

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt1;
      id_q     <= '0;
      type_q   <= '0;
      len_lo_q <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcInit;
      rcrc_q   <= '0;
      disc_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      id_q     <= id_d;
      type_q   <= type_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      rcrc_q   <= rcrc_d;
      disc_q   <= disc_d;
    end
  end

endmodule

[hdl/crcfd_release.sv]
// Release sequencer: reads buffered payload bytes back and drives output beats.
// Depends on crcfd_pkg; reads the crcfd_ram buffer through its registered port.
module crcfd_release import crcfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rel_req_t            req_i,
  output logic                busy_o,
  output logic                rd_en_o,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr_o,
  input  logic [7:0]          rd_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_beat_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic       busy_q, busy_d;
  logic       pend_q, pend_d;
  logic [6:0] idx_q, idx_d;
  rel_req_t   cur_q, cur_d;
  logic       ovalid_q, ovalid_d;
  out_beat_t  obeat_q, obeat_d;

  logic       slot_free;
  logic [6:0] idx_inc;

  // output register empty now or emptied this cycle
  assign slot_free = !ovalid_q || !out_stall_i;
  assign idx_inc   = idx_q + 7'd1;

  always_comb begin
    busy_d   = busy_q;
    pend_d   = pend_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q && out_stall_i;
    obeat_d  = obeat_q;
    rd_en_o  = 1'b0;

    // new frame to release
    if (req_i.start) begin
      busy_d = 1'b1;
      cur_d  = req_i;
      idx_d  = 7'd0;
    end

    if (pend_q) begin
      // read data back: load one payload beat
      ovalid_d = 1'b1;
      obeat_d  = '{pkt_id: cur_q.pkt_id, pkt_type: cur_q.pkt_type,
                   payload_length: cur_q.length, payload_byte: rd_data_i,
                   byte_position: idx_q[5:0], has_payload: 1'b1,
                   last: (idx_inc == cur_q.length)};
      idx_d    = idx_inc;
      pend_d   = 1'b0;
      if (idx_inc == cur_q.length) begin
        busy_d = 1'b0;
      end
    end else if (busy_q && slot_free) begin
      if (cur_q.length == 7'd0) begin
        // empty frame marker
        ovalid_d = 1'b1;
        obeat_d  = '{pkt_id: cur_q.pkt_id, pkt_type: cur_q.pkt_type,
                     payload_length: 7'd0, payload_byte: 8'h00,
                     byte_position: 6'd0, has_payload: 1'b0, last: 1'b1};
        busy_d   = 1'b0;
      end else begin
        rd_en_o = 1'b1;
        pend_d  = 1'b1;
      end
    end
  end

  assign rd_addr_o   = idx_q[AddrW-1:0];
  assign busy_o      = busy_q;
  assign out_valid_o = ovalid_q;
  assign out_beat_o  = obeat_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    obeat_q <= obeat_d;
  end

endmodule

[hdl/crc16_framed_packet_deframer.sv]
// Top level of the CRC-16/MODBUS framed packet deframer.
// Depends on crcfd_pkg, crcfd_ram, crcfd_parser and crcfd_release.
//
//  Channel  Signals                           Direction  Beat
//  in       in_valid_i, in_stall_o, in_beat_i  input      one received byte
//  out      out_valid_o, out_stall_i, out_beat_o output   one payload byte or
//                                                         the empty marker
//
// A received byte is taken while no frame is being released; the parser state
// lives in registers and payload bytes go into a MAX_PAYLOAD-deep RAM.
// When a frame passes, input stalls while its bytes are read back: each payload
// result goes through a RAM read, then the output register, the empty marker
// only through the output register, and out_stall_i can hold either.
// The output register lets the next byte in while the last result waits.
// Reset is asynchronous, active low; the RAM needs no clearing.
module crc16_framed_packet_deframer import crcfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             accept;
  logic             busy;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  rel_req_t         req;

  // input held off while a frame is being released
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  crcfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .req_o    (req)
  );

  crcfd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  crcfd_release #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_release (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule
